### hw/rtl/multibyte_text_glyph_decoder_core_assert.svh
// assertion macros used by the checker file
`ifndef MULTIBYTE_TEXT_GLYPH_DECODER_CORE_ASSERT_SVH
`define MULTIBYTE_TEXT_GLYPH_DECODER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MTGD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("glyph decoder check failed");

// next-cycle implication, disabled during reset
`define MTGD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("glyph decoder check failed");

`endif

### hw/rtl/mtgd_pkg.sv
// shared types and constants of the glyph decoder
package mtgd_pkg;

    // language modes
    localparam logic [1:0] MODE_SINGLE = 2'd0;
    localparam logic [1:0] MODE_SJIS   = 2'd1;
    localparam logic [1:0] MODE_EUC    = 2'd2;
    localparam logic [1:0] MODE_HANGUL = 2'd3;

    // font banks
    localparam logic [1:0] BANK_SINGLE = 2'd0;
    localparam logic [1:0] BANK_JP     = 2'd1;
    localparam logic [1:0] BANK_HANGUL = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LANG_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HANGUL    = 1'b1;

    // number of draw commands produced by one byte
    localparam logic [1:0] RES_NONE = 2'd0;
    localparam logic [1:0] RES_ONE  = 2'd1;
    localparam logic [1:0] RES_TWO  = 2'd2;

    // decoder state held between bytes
    typedef struct packed {
        logic [7:0] lead;
        logic [7:0] second;
    } t_pend;

    // decoder verdict for one byte
    typedef struct packed {
        logic [1:0]  n_res;
        logic [1:0]  bank;
        logic [19:0] offset;
        logic        advance;
        t_pend       pend;
    } t_dec;

    // one draw command
    typedef struct packed {
        logic [1:0]         font_bank;
        logic signed [19:0] glyph_offset;
        logic signed [15:0] draw_x;
        logic [11:0]        draw_y;
        logic [7:0]         draw_color;
        logic               last;
    } t_result;

endpackage

### hw/rtl/mtgd_if.sv
// request channels of the glyph decoder

// text byte requests
interface mtgd_in_if;
    logic               valid;
    logic               ready;
    logic [7:0]         code_byte;
    logic               string_start;
    logic signed [15:0] start_x;
    logic [11:0]        text_y;
    logic [7:0]         color;

    modport source (output valid, code_byte, string_start, start_x, text_y, color,
                    input ready);
    modport sink   (input valid, code_byte, string_start, start_x, text_y, color,
                    output ready);
endinterface

// draw command requests
interface mtgd_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         font_bank;
    logic signed [19:0] glyph_offset;
    logic signed [15:0] draw_x;
    logic [11:0]        draw_y;
    logic [7:0]         draw_color;
    logic               last;

    modport source (output valid, font_bank, glyph_offset, draw_x, draw_y, draw_color,
                    last, input ready);
    modport sink   (input valid, font_bank, glyph_offset, draw_x, draw_y, draw_color,
                    last, output ready);
endinterface

// configuration write requests
interface mtgd_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [mtgd_pkg::CFG_IDX_W-1:0]     index;
    logic [mtgd_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/mtgd_decode.sv
// byte decoder: mode rules, glyph offsets and next pending bytes
module mtgd_decode (
    input  logic [7:0]       i_byte,
    input  logic [1:0]       i_lang_mode,
    input  logic             i_hangul_present,
    input  mtgd_pkg::t_pend  i_pend,
    output mtgd_pkg::t_dec   o_dec
);

    logic [10:0] sj_k;
    logic [10:0] sj_t;
    logic [10:0] euc_k;
    logic [10:0] euc_t;
    logic [19:0] sj_off;
    logic [19:0] euc_off;
    logic [15:0] cp;
    logic [15:0] cp_rel;
    logic [19:0] hg_off;
    logic        cp_ok;
    logic        b_cont;
    logic        sj_lead_ok;
    logic [19:0] single_off;

    // offset of a two-byte glyph, modulo 2^20
    function automatic logic [19:0] jis_off(logic [10:0] k, logic [10:0] t);
        logic [19:0] kx;
        logic [19:0] tx;
        kx = {{9{k[10]}}, k};
        tx = {{9{t[10]}}, t};
        return 20'd4096 + ((kx * 20'd94 + tx) << 5);
    endfunction

    // shift-jis row and cell, signed 11-bit
    always_comb begin
        if (i_pend.lead inside {[8'h81:8'h9f]}) begin
            sj_k = ({3'b0, i_pend.lead} - 11'h081) << 1;
        end else begin
            sj_k = (({3'b0, i_pend.lead} - 11'h0e0) << 1) + 11'd62;
        end
        if (i_byte inside {[8'h40:8'h7e]}) begin
            sj_t = {3'b0, i_byte} - 11'h040;
        end else if (i_byte inside {[8'h80:8'h9e]}) begin
            sj_t = {3'b0, i_byte} - 11'h080 + 11'd63;
        end else begin
            sj_t = {3'b0, i_byte} - 11'h09f;
            sj_k = sj_k + 11'd1;
        end
    end

    // euc-jp row and cell, may go negative
    assign euc_k   = {3'b0, i_pend.lead} - 11'h0a1;
    assign euc_t   = {3'b0, i_byte} - 11'h0a1;
    assign sj_off  = jis_off(sj_k, sj_t);
    assign euc_off = jis_off(euc_k, euc_t);

    // utf-8 hangul code point
    assign cp     = {i_pend.lead[3:0], i_pend.second[5:0], i_byte[5:0]};
    assign cp_ok  = (cp >= 16'hac00) && (cp <= 16'hd7a3);
    assign cp_rel = cp - 16'hac00;
    assign hg_off = 20'd4096 + ({4'b0, cp_rel} << 5);
    assign b_cont = i_byte inside {[8'h80:8'hbf]};

    assign sj_lead_ok = (i_byte inside {[8'h81:8'h9f]}) || (i_byte inside {[8'he0:8'hfc]});
    assign single_off = {8'b0, i_byte, 4'b0};

    // per-mode decision
    always_comb begin
        o_dec.n_res   = mtgd_pkg::RES_ONE;
        o_dec.bank    = mtgd_pkg::BANK_SINGLE;
        o_dec.offset  = single_off;
        o_dec.advance = 1'b1;
        o_dec.pend    = i_pend;
        case (i_lang_mode)
            mtgd_pkg::MODE_SINGLE: begin
            end
            mtgd_pkg::MODE_SJIS: begin
                o_dec.bank = mtgd_pkg::BANK_JP;
                if (i_pend.lead == 8'h00) begin
                    if (sj_lead_ok) begin
                        o_dec.n_res     = mtgd_pkg::RES_NONE;
                        o_dec.pend.lead = i_byte;
                    end
                end else begin
                    o_dec.n_res     = mtgd_pkg::RES_TWO;
                    o_dec.offset    = sj_off;
                    o_dec.pend.lead = 8'h00;
                end
            end
            mtgd_pkg::MODE_EUC: begin
                o_dec.bank = mtgd_pkg::BANK_JP;
                if (i_pend.lead == 8'h00) begin
                    if (i_byte inside {[8'h81:8'hfe]}) begin
                        o_dec.n_res     = mtgd_pkg::RES_NONE;
                        o_dec.pend.lead = i_byte;
                    end
                end else begin
                    o_dec.n_res     = mtgd_pkg::RES_TWO;
                    o_dec.offset    = euc_off;
                    o_dec.pend.lead = 8'h00;
                end
            end
            mtgd_pkg::MODE_HANGUL: begin
                if (!i_hangul_present) begin
                end else if (i_pend.lead == 8'h00) begin
                    if (i_byte inside {[8'hea:8'hed]}) begin
                        o_dec.n_res     = mtgd_pkg::RES_NONE;
                        o_dec.pend.lead = i_byte;
                    end
                end else if (i_pend.second == 8'h00) begin
                    if (b_cont) begin
                        o_dec.n_res       = mtgd_pkg::RES_NONE;
                        o_dec.pend.second = i_byte;
                        o_dec.advance     = 1'b0;
                    end else begin
                        o_dec.pend.lead = 8'h00;
                    end
                end else begin
                    o_dec.pend.lead   = 8'h00;
                    o_dec.pend.second = 8'h00;
                    if (b_cont && cp_ok) begin
                        o_dec.n_res  = mtgd_pkg::RES_TWO;
                        o_dec.bank   = mtgd_pkg::BANK_HANGUL;
                        o_dec.offset = hg_off;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

### hw/rtl/multibyte_text_glyph_decoder_core.sv
// glyph decoder top: byte intake, pen and pending state, draw command buffer
// a draw command is registered and shows on the output in the cycle after its byte is taken
// intake takes one byte per cycle while the output is not stalled; a double-width glyph
// holds intake until its left half is taken from the two-entry command buffer
// reset (synchronous, active low) clears mode, font flag, pending bytes, pen x
// and empties the command buffer
module multibyte_text_glyph_decoder_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mtgd_in_if.sink           i_in,
    mtgd_out_if.source        o_out,
    mtgd_cfg_if.sink          i_cfg
);

    logic [1:0]             r_lang_mode;
    logic                   r_hangul;
    mtgd_pkg::t_pend        r_pend;
    logic [15:0]            r_pen_x;
    logic [1:0]             r_cnt;
    logic [1:0]             n_cnt;
    mtgd_pkg::t_result      r_res0;
    mtgd_pkg::t_result      r_res1;
    mtgd_pkg::t_result      n_res0;
    mtgd_pkg::t_result      n_res1;
    mtgd_pkg::t_result      res_first;
    mtgd_pkg::t_result      res_second;
    mtgd_pkg::t_dec         dec;
    logic [15:0]            base_x;
    logic                   accept;
    logic                   pop;
    logic                   dbl;

    // configuration writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lang_mode <= mtgd_pkg::MODE_SINGLE;
            r_hangul    <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                mtgd_pkg::REG_LANG_MODE: r_lang_mode <= i_cfg.data[1:0];
                mtgd_pkg::REG_HANGUL:    r_hangul    <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    // handshakes
    assign o_out.valid = (r_cnt != mtgd_pkg::RES_NONE);
    assign pop         = o_out.valid && o_out.ready;
    assign i_in.ready  = (r_cnt == mtgd_pkg::RES_NONE) ||
                         ((r_cnt == mtgd_pkg::RES_ONE) && o_out.ready);
    assign accept      = i_in.valid && i_in.ready;

    // pen start for this byte
    assign base_x = i_in.string_start ? i_in.start_x : r_pen_x;

    mtgd_decode u_decode (
        .i_byte           (i_in.code_byte),
        .i_lang_mode      (r_lang_mode),
        .i_hangul_present (r_hangul),
        .i_pend           (r_pend),
        .o_dec            (dec)
    );

    // draw commands for this byte
    assign dbl = (dec.n_res == mtgd_pkg::RES_TWO);

    always_comb begin
        res_first.font_bank    = dec.bank;
        res_first.glyph_offset = dec.offset;
        res_first.draw_x       = dbl ? (base_x - 16'd8) : base_x;
        res_first.draw_y       = i_in.text_y;
        res_first.draw_color   = i_in.color;
        res_first.last         = !dbl;

        res_second              = res_first;
        res_second.glyph_offset = dec.offset + 20'd16;
        res_second.draw_x       = base_x;
        res_second.last         = 1'b1;
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= '0;
            r_pen_x <= 16'd0;
        end else if (accept) begin
            r_pend  <= dec.pend;
            r_pen_x <= dec.advance ? (base_x + 16'd8) : base_x;
        end
    end

    // command buffer next state
    always_comb begin
        n_cnt  = r_cnt;
        n_res0 = r_res0;
        n_res1 = r_res1;
        if (pop) begin
            if (r_cnt == mtgd_pkg::RES_TWO) begin
                n_res0 = r_res1;
                n_cnt  = mtgd_pkg::RES_ONE;
            end else begin
                n_cnt = mtgd_pkg::RES_NONE;
            end
        end
        if (accept) begin
            n_cnt  = dec.n_res;
            n_res0 = res_first;
            n_res1 = res_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= mtgd_pkg::RES_NONE;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res0 <= n_res0;
        r_res1 <= n_res1;
    end

    // output payload
    assign o_out.font_bank    = r_res0.font_bank;
    assign o_out.glyph_offset = r_res0.glyph_offset;
    assign o_out.draw_x       = r_res0.draw_x;
    assign o_out.draw_y       = r_res0.draw_y;
    assign o_out.draw_color   = r_res0.draw_color;
    assign o_out.last         = r_res0.last;

endmodule

### hw/rtl/mtgd_checker.sv
// port-level checks of the glyph decoder and their binding
`include "multibyte_text_glyph_decoder_core_assert.svh"

module mtgd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_ready,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_font_bank,
    input  logic [19:0] i_glyph_offset,
    input  logic [15:0] i_draw_x,
    input  logic        i_last
);

    // stalled command holds
    `MTGD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_glyph_offset) && $stable(i_draw_x))

    // no new byte while a left half waits
    `MTGD_ASSERT_NOW(a_left_blocks_in, i_clk, i_rst_n, i_out_valid && !i_last, !i_in_ready)

    // right half follows its left half, 8 pixels on, same bank
    `MTGD_ASSERT_NEXT(a_right_half, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_last, i_out_valid && i_last && (i_draw_x == 16'($past(i_draw_x) + 16'd8)) && (i_font_bank == $past(i_font_bank)) && (i_glyph_offset == 20'($past(i_glyph_offset) + 20'd16)))

    // only three banks exist
    `MTGD_ASSERT_NOW(a_bank_range, i_clk, i_rst_n, i_out_valid, i_font_bank != 2'd3)

endmodule

bind multibyte_text_glyph_decoder_core mtgd_checker u_mtgd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_font_bank    (o_out.font_bank),
    .i_glyph_offset (o_out.glyph_offset),
    .i_draw_x       (o_out.draw_x),
    .i_last         (o_out.last)
);
